// File: rtl/circle_overlap_resolve_top_macros.svh
// Assertion macros for the circle overlap resolver.
// Expects clk and arst_n in the including scope.
`ifndef CIRCLE_OVERLAP_RESOLVE_TOP_MACROS_SVH
`define CIRCLE_OVERLAP_RESOLVE_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define COR_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define COR_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/cor_pkg.sv
// Shared widths and sideband types for the circle overlap resolver.
// No dependencies.
package cor_pkg;

	localparam int SQ_IN_W  = 67;	// dx^2 + dy^2
	localparam int ROOT_W   = 34;	// floor sqrt of the above
	localparam int SQ_REM_W = 70;	// remainder and trial width in the root stages
	localparam int NUM_W    = 64;	// |d| * depth
	localparam int DEN_W    = 33;	// 2 * distance
	localparam int DIV_W    = 32;	// quotient bits

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic               ndx;
		logic               ndy;
		logic [31:0]        mdx;
		logic [31:0]        mdy;
		logic [31:0]        rsum;
		logic               trig;
	} cor_side_t;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic               ndx;
		logic               ndy;
		logic               push;
		logic               hit;
	} cor_dside_t;

endpackage

// File: rtl/cor_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on cor_pkg.
module cor_sqrt import cor_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SQ_IN_W-1:0]  rad,
	output logic [ROOT_W-1:0]   root
);

	logic [SQ_REM_W-1:0] rem_s [1:ROOT_W-1];
	logic [ROOT_W-1:0]   q_s   [1:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_st
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_REM_W-1:0] rin;
		logic [ROOT_W-1:0]   qin;
		logic [SQ_REM_W-1:0] trial;
		logic                ge;

		if (k == 0) begin : g_first
			assign rin = SQ_REM_W'(rad);
			assign qin = '0;
		end else begin : g_mid
			assign rin = rem_s[k];
			assign qin = q_s[k];
		end

		// (q + 2^B)^2 - q^2, with q holding only bits above B
		assign trial = (SQ_REM_W'(qin) << (B + 1)) | (SQ_REM_W'(1) << (2 * B));
		assign ge    = rin >= trial;

		if (k < ROOT_W - 1) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? rin - trial : rin;
					q_s[k+1]   <= ge ? qin | (ROOT_W'(1) << B) : qin;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					root <= ge ? qin | (ROOT_W'(1) << B) : qin;
				end
			end
		end
	end

endmodule

// File: rtl/cor_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cor_pkg; the caller keeps num >> 32 below den.
module cor_div import cor_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [DIV_W-1:0]  quot
);

	logic [DEN_W-1:0] rem_s [1:DIV_W-1];
	logic [DIV_W-1:0] lo_s  [1:DIV_W-1];
	logic [DEN_W-1:0] den_s [1:DIV_W-1];
	logic [DIV_W-1:0] q_s   [1:DIV_W-1];

	for (genvar j = 0; j < DIV_W; j++) begin : g_st
		logic [DEN_W-1:0] rin;
		logic [DIV_W-1:0] lin;
		logic [DEN_W-1:0] din;
		logic [DIV_W-1:0] qin;
		logic [DEN_W:0]   r2;
		logic             ge;

		if (j == 0) begin : g_first
			assign rin = DEN_W'(num[NUM_W-1:DIV_W]);
			assign lin = num[DIV_W-1:0];
			assign din = den;
			assign qin = '0;
		end else begin : g_mid
			assign rin = rem_s[j];
			assign lin = lo_s[j];
			assign din = den_s[j];
			assign qin = q_s[j];
		end

		assign r2 = {rin, lin[DIV_W-1]};
		assign ge = r2 >= {1'b0, din};

		if (j < DIV_W - 1) begin : g_reg
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= ge ? DEN_W'(r2 - {1'b0, din}) : DEN_W'(r2);
					lo_s[j+1]  <= lin << 1;
					den_s[j+1] <= din;
					q_s[j+1]   <= {qin[DIV_W-2:0], ge};
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					quot <= {qin[DIV_W-2:0], ge};
				end
			end
		end
	end

endmodule

// File: rtl/circle_overlap_resolve_top.sv
// One word per cycle unless stalled, through 34-stage root and 32-stage divider pipes.
// The pipe advances whenever the output skid slot is empty, so bubbles never block it.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
// Depends on cor_pkg, cor_sqrt, cor_div and the assertion macro header.
`include "circle_overlap_resolve_top_macros.svh"
module circle_overlap_resolve_top import cor_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_pos_x, a_pos_y, a_scale_x, a_scale_y, a_size, b_pos_x, b_pos_y,
	// b_scale_x, b_scale_y, b_size
	input  logic [223:0] s_axis_tdata,
	input  logic [0:0]   s_axis_tuser,	// trigger_only
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,	// new_a_x, new_a_y, new_b_x, new_b_y
	output logic [0:0]   m_axis_tuser	// hit
);

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -34'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	logic en;
	logic skid_v_q, out_v_q;
	logic [128:0] skid_q, out_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	// ---- input unpack ----
	logic signed [31:0] in_ax, in_ay, in_bx, in_by;
	logic [15:0] in_asx, in_asy, in_asz, in_bsx, in_bsy, in_bsz;
	assign in_ax  = s_axis_tdata[31:0];
	assign in_ay  = s_axis_tdata[63:32];
	assign in_asx = s_axis_tdata[79:64];
	assign in_asy = s_axis_tdata[95:80];
	assign in_asz = s_axis_tdata[111:96];
	assign in_bx  = s_axis_tdata[143:112];
	assign in_by  = s_axis_tdata[175:144];
	assign in_bsx = s_axis_tdata[191:176];
	assign in_bsy = s_axis_tdata[207:192];
	assign in_bsz = s_axis_tdata[223:208];

	// ---- stages 1..7 ----
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [31:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [31:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [31:0] ax_s3, ay_s3, bx_s3, by_s3;
	logic [15:0] ma_s1, mb_s1, asz_s1, bsz_s1;
	logic trig_s1, trig_s2, trig_s3;
	logic [30:0] ra_s2, rb_s2;
	logic signed [33:0] dx_s3, dy_s3;
	logic [31:0] rsum_s3;
	logic [32:0] mdx_s4, mdy_s4;
	cor_side_t side_s4, side_s5, side_s6, side_s7;
	logic [33:0] hx_s5, hy_s5;
	logic [32:0] mx_s5, my_s5;
	logic [31:0] lx_s5, ly_s5;
	logic [65:0] sqx_s6, sqy_s6;
	logic [SQ_IN_W-1:0] sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{s_axis_tvalid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= in_ax;
			ay_s1   <= in_ay;
			bx_s1   <= in_bx;
			by_s1   <= in_by;
			ma_s1   <= (in_asx > in_asy) ? in_asx : in_asy;
			mb_s1   <= (in_bsx > in_bsy) ? in_bsx : in_bsy;
			asz_s1  <= in_asz;
			bsz_s1  <= in_bsz;
			trig_s1 <= s_axis_tuser[0];

			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			ra_s2   <= 31'((32'(ma_s1) * 32'(asz_s1)) >> 1);
			rb_s2   <= 31'((32'(mb_s1) * 32'(bsz_s1)) >> 1);
			trig_s2 <= trig_s1;

			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;
			dx_s3   <= 34'(ax_s2) - 34'(bx_s2) + 34'(ra_s2) - 34'(rb_s2);
			dy_s3   <= 34'(ay_s2) - 34'(by_s2) + 34'(ra_s2) - 34'(rb_s2);
			rsum_s3 <= 32'(ra_s2) + 32'(rb_s2);
			trig_s3 <= trig_s2;

			mdx_s4       <= dx_s3[33] ? 33'(-dx_s3) : 33'(dx_s3);
			mdy_s4       <= dy_s3[33] ? 33'(-dy_s3) : 33'(dy_s3);
			side_s4.ax   <= ax_s3;
			side_s4.ay   <= ay_s3;
			side_s4.bx   <= bx_s3;
			side_s4.by   <= by_s3;
			side_s4.ndx  <= dx_s3[33];
			side_s4.ndy  <= dy_s3[33];
			side_s4.mdx  <= dx_s3[33] ? 32'(-dx_s3) : 32'(dx_s3);
			side_s4.mdy  <= dy_s3[33] ? 32'(-dy_s3) : 32'(dy_s3);
			side_s4.rsum <= rsum_s3;
			side_s4.trig <= trig_s3;

			// squares split into 17 x 16 bit halves
			hx_s5   <= 34'(mdx_s4[32:16]) * 34'(mdx_s4[32:16]);
			mx_s5   <= 33'(mdx_s4[32:16]) * 33'(mdx_s4[15:0]);
			lx_s5   <= 32'(mdx_s4[15:0]) * 32'(mdx_s4[15:0]);
			hy_s5   <= 34'(mdy_s4[32:16]) * 34'(mdy_s4[32:16]);
			my_s5   <= 33'(mdy_s4[32:16]) * 33'(mdy_s4[15:0]);
			ly_s5   <= 32'(mdy_s4[15:0]) * 32'(mdy_s4[15:0]);
			side_s5 <= side_s4;

			sqx_s6  <= (66'(hx_s5) << 32) + (66'(mx_s5) << 17) + 66'(lx_s5);
			sqy_s6  <= (66'(hy_s5) << 32) + (66'(my_s5) << 17) + 66'(ly_s5);
			side_s6 <= side_s5;

			sum_s7  <= SQ_IN_W'(sqx_s6) + SQ_IN_W'(sqy_s6);
			side_s7 <= side_s6;
		end
	end

	// ---- root, stages 8..41 ----
	logic [ROOT_W-1:0] distance;
	logic              rv_s [0:ROOT_W-1];
	cor_side_t         rs_s [0:ROOT_W-1];

	cor_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s7),
		.root (distance)
	);

	for (genvar k = 0; k < ROOT_W; k++) begin : g_rside
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[k] <= 1'b0;
			end else if (en) begin
				rv_s[k] <= (k == 0) ? v_s7 : rv_s[(k == 0) ? 0 : k - 1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rs_s[k] <= (k == 0) ? side_s7 : rs_s[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// ---- depth and gating, stage 42; product, stage 43 ----
	cor_side_t rsl;
	logic signed [35:0] depth;
	logic hit_c, push_c;
	assign rsl    = rs_s[ROOT_W-1];
	assign depth  = 36'(rsl.rsum) - 36'(distance);
	assign hit_c  = !depth[35] && (depth != '0);
	assign push_c = hit_c && !rsl.trig && (distance != '0);

	logic v_s42, v_s43;
	cor_dside_t ds_s42, ds_s43;
	logic [31:0] opx_s42, opy_s42, dep_s42;
	logic [DEN_W-1:0] den_s42, den_s43;
	logic [NUM_W-1:0] px_s43, py_s43;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s42 <= 1'b0;
			v_s43 <= 1'b0;
		end else if (en) begin
			v_s42 <= rv_s[ROOT_W-1];
			v_s43 <= v_s42;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds_s42.ax   <= rsl.ax;
			ds_s42.ay   <= rsl.ay;
			ds_s42.bx   <= rsl.bx;
			ds_s42.by   <= rsl.by;
			ds_s42.ndx  <= rsl.ndx;
			ds_s42.ndy  <= rsl.ndy;
			ds_s42.push <= push_c;
			ds_s42.hit  <= hit_c;
			// zeroed operands keep the divider's high word below the divisor
			opx_s42     <= push_c ? rsl.mdx : '0;
			opy_s42     <= push_c ? rsl.mdy : '0;
			dep_s42     <= depth[31:0];
			den_s42     <= push_c ? {distance[31:0], 1'b0} : DEN_W'(1);

			px_s43  <= 64'(opx_s42) * 64'(dep_s42);
			py_s43  <= 64'(opy_s42) * 64'(dep_s42);
			den_s43 <= den_s42;
			ds_s43  <= ds_s42;
		end
	end

	// ---- push division, stages 44..75 ----
	logic [DIV_W-1:0] qx, qy;
	logic             dv_s [0:DIV_W-1];
	cor_dside_t       dd_s [0:DIV_W-1];

	cor_div u_div_x (
		.clk  (clk),
		.en   (en),
		.num  (px_s43),
		.den  (den_s43),
		.quot (qx)
	);

	cor_div u_div_y (
		.clk  (clk),
		.en   (en),
		.num  (py_s43),
		.den  (den_s43),
		.quot (qy)
	);

	for (genvar j = 0; j < DIV_W; j++) begin : g_dside
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j] <= 1'b0;
			end else if (en) begin
				dv_s[j] <= (j == 0) ? v_s43 : dv_s[(j == 0) ? 0 : j - 1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dd_s[j] <= (j == 0) ? ds_s43 : dd_s[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// ---- final add and clamp ----
	cor_dside_t dl;
	logic v_last;
	logic signed [32:0] pshx, pshy;
	logic [128:0] res;
	assign dl     = dd_s[DIV_W-1];
	assign v_last = dv_s[DIV_W-1];
	assign pshx   = dl.push ? (dl.ndx ? -33'(qx) : 33'(qx)) : '0;
	assign pshy   = dl.push ? (dl.ndy ? -33'(qy) : 33'(qy)) : '0;
	assign res    = {dl.hit,
	                 sat32(34'(dl.by) - 34'(pshy)),
	                 sat32(34'(dl.bx) - 34'(pshx)),
	                 sat32(34'(dl.ay) + 34'(pshy)),
	                 sat32(34'(dl.ax) + 34'(pshx))};

	// ---- output register with skid slot ----
	logic take;
	assign take = out_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (v_last) begin
			if (out_v_q && !take)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take)
				out_q <= skid_q;
		end else if (v_last) begin
			if (out_v_q && !take)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q[127:0];
	assign m_axis_tuser  = out_q[128:128];

	`COR_ASSERT_NOW(a_skid_out, skid_v_q, out_v_q, "skid word held with no output word")
	`COR_ASSERT_NEXT(a_skid_fill, v_last && out_v_q && !m_axis_tready && !skid_v_q, skid_v_q, "stalled word not caught by skid slot")
	`COR_ASSERT_NOW(a_push_hit, v_last && dl.push, dl.hit, "push applied without a hit")

endmodule

// File: tb/sv/testbench.sv
// Testbench for circle_overlap_resolve_top: directed table then random circle pairs.
// Each accepted word is checked against a local fixed-point predictor.
// Depends on the RTL top level, which uses cor_pkg.
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic signed [31:0] ax, ay;
		logic [15:0]        asx, asy, asz;
		logic signed [31:0] bx, by;
		logic [15:0]        bsx, bsy, bsz;
		logic               trig;
	} pair_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] nax, nay, nbx, nby;
	} moved_t;

	typedef struct {
		pair_t  p;
		logic   typed;
		moved_t r;
	} row_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int N_RANDOM     = 1230;
	localparam int DRAIN_CYCLES = 120;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	moved_t pending_moves[$];
	int     fails = 0;
	int     cycle_count = 0;
	int     idle_pct = 20;

	always #5 clk = ~clk;

	circle_overlap_resolve_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	function automatic longint radius_q16(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
		longint m;
		m = (sx > sy) ? longint'(sx) : longint'(sy);
		return (m * longint'(sz)) >>> 1;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic moved_t resolve_pair(pair_t p);
		longint ax, ay, bx, by, ra, rb, dx, dy, distance, depth, px, py;
		logic [127:0] wx, wy, sq, root, cand, q;
		moved_t r;
		ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
		ra = radius_q16(p.asx, p.asy, p.asz);
		rb = radius_q16(p.bsx, p.bsy, p.bsz);
		dx = (ax + ra) - (bx + rb);
		dy = (ay + ra) - (by + rb);
		wx = (dx < 0) ? -dx : dx;
		wy = (dy < 0) ? -dy : dy;
		sq = wx * wx + wy * wy;
		root = '0;
		for (int b = 35; b >= 0; b--) begin
			cand = root | (128'd1 << b);
			if (cand * cand <= sq)
				root = cand;
		end
		distance = root[63:0];
		depth = (ra + rb) - distance;
		r.hit = depth > 0;
		if (r.hit && !p.trig && distance != 0) begin
			q = (wx * depth) / (128'd2 * distance);
			px = (dx < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
			q = (wy * depth) / (128'd2 * distance);
			py = (dy < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
			ax += px; ay += py; bx -= px; by -= py;
		end
		r.nax = clamp32(ax); r.nay = clamp32(ay);
		r.nbx = clamp32(bx); r.nby = clamp32(by);
		return r;
	endfunction

	// mostly nearby pairs with randomly shrunken scales so pushes happen; the rest is raw noise
	function automatic pair_t random_pair();
		pair_t p;
		logic signed [31:0] ox, oy;
		p.ax = $urandom; p.ay = $urandom;
		p.asx = $urandom; p.asy = $urandom; p.asz = $urandom;
		p.bsx = $urandom; p.bsy = $urandom; p.bsz = $urandom;
		p.bx = $urandom; p.by = $urandom;
		p.trig = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 99) < 80) begin
			p.asx = p.asx >> $urandom_range(0, 15);
			p.asy = p.asy >> $urandom_range(0, 15);
			p.asz = p.asz >> $urandom_range(0, 15);
			p.bsx = p.bsx >> $urandom_range(0, 15);
			p.bsy = p.bsy >> $urandom_range(0, 15);
			p.bsz = p.bsz >> $urandom_range(0, 15);
			ox = $urandom; oy = $urandom;
			ox = ox >>> $urandom_range(0, 31);
			oy = oy >>> $urandom_range(0, 31);
			p.bx = p.ax + ox;
			p.by = p.ay + oy;
		end
		return p;
	endfunction

	task automatic send_pair(pair_t p);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.bsz, p.bsy, p.bsx, p.by, p.bx, p.asz, p.asy, p.asx, p.ay, p.ax};
		s_axis_tuser <= p.trig;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_moves.push_back(resolve_pair(p));
	endtask

	function automatic pair_t mk(logic signed [31:0] ax, ay, logic [15:0] asx, asy, asz,
			logic signed [31:0] bx, by, logic [15:0] bsx, bsy, bsz, logic trig);
		pair_t p;
		p.ax = ax; p.ay = ay; p.asx = asx; p.asy = asy; p.asz = asz;
		p.bx = bx; p.by = by; p.bsx = bsx; p.bsy = bsy; p.bsz = bsz; p.trig = trig;
		return p;
	endfunction

	function automatic moved_t mv(logic hit, logic signed [31:0] nax, nay, nbx, nby);
		moved_t r;
		r.hit = hit; r.nax = nax; r.nay = nay; r.nbx = nbx; r.nby = nby;
		return r;
	endfunction

	row_t directed[$];

	initial begin
		localparam logic signed [31:0] PMAX = 32'sh7fffffff;
		localparam logic signed [31:0] PMIN = 32'sh80000000;
		row_t row;
		moved_t got;
		// zero-size circles: no overlap
		directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mv(0, 0, 0, 0, 0)});
		// coincident centres, unit circles: hit with no push
		directed.push_back('{mk(0, 0, 256, 256, 256, 0, 0, 256, 256, 256, 0), 1,
			mv(1, 0, 0, 0, 0)});
		// trigger only: overlap reported, positions unchanged
		directed.push_back('{mk(0, 0, 256, 256, 256, 32'h8000, 0, 256, 256, 256, 1), 1,
			mv(1, 0, 0, 32'h8000, 0)});
		// far apart at the ends of the range
		directed.push_back('{mk(PMAX, PMAX, 0, 0, 0, PMIN, PMIN, 0, 0, 0, 0), 1,
			mv(0, PMAX, PMAX, PMIN, PMIN)});
		// largest circles, coincident at top corner
		directed.push_back('{mk(PMAX, PMAX, 16'hffff, 16'hffff, 16'hffff,
			PMAX, PMAX, 16'hffff, 16'hffff, 16'hffff, 0), 1, mv(1, PMAX, PMAX, PMAX, PMAX)});
		directed.push_back('{mk(PMAX, PMAX, 16'hffff, 16'hffff, 16'hffff,
			PMAX, PMAX, 16'hffff, 16'hffff, 16'hffff, 1), 1, mv(1, PMAX, PMAX, PMAX, PMAX)});
		// push with the rest predicted: axis-aligned, diagonal, saturation, rounding edge
		directed.push_back('{mk(0, 0, 256, 256, 256, 32'h8000, 0, 256, 256, 256, 0), 0, 'x});
		directed.push_back('{mk(0, 0, 512, 256, 256, 0, -32'sh4000, 256, 512, 256, 0), 0, 'x});
		directed.push_back('{mk(32'h1000, 32'h2000, 300, 700, 900, 32'h3000, 0, 800, 100,
			500, 0), 0, 'x});
		directed.push_back('{mk(32'h7fff0000, 0, 16'hffff, 0, 16'hffff, 32'h7ffe0000, 0,
			16'hffff, 0, 16'hffff, 0), 0, 'x});
		directed.push_back('{mk(PMIN, PMIN, 16'hffff, 16'hffff, 16'hffff, PMIN + 1, PMIN,
			16'hffff, 16'hffff, 16'hffff, 0), 0, 'x});
		directed.push_back('{mk(0, 0, 256, 0, 256, 32'h10000, 0, 0, 256, 256, 0), 0, 'x});
		directed.push_back('{mk(0, 0, 256, 0, 256, 32'hffff, 0, 0, 256, 256, 0), 0, 'x});
		directed.push_back('{mk(0, 0, 256, 256, 256, 32'h5000, 32'h6000, 256, 256, 256, 0),
			0, 'x});
		directed.push_back('{mk(-32'sh5000, -32'sh6000, 16'h00ff, 16'h0100, 16'h8000,
			0, 0, 16'h8000, 16'h0001, 16'h0100, 0), 0, 'x});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.typed) begin
				got = resolve_pair(row.p);
				// typed rows also go through the predictor queue; flag a table slip
				if (got !== row.r) begin
					$error("row %0d: tabled hit=%0b ax=%0d, predicted hit=%0b ax=%0d",
						i, row.r.hit, row.r.nax, got.hit, got.nax);
					fails++;
				end
			end
			send_pair(row.p);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			idle_pct = (n >= 400 && n < 700) ? 0 : 20;
			send_pair(random_pair());
		end
		s_axis_tvalid <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= (idle_pct == 0) || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin
		moved_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_moves.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				want = pending_moves.pop_front();
				if (m_axis_tuser[0] !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, m_axis_tuser[0]);
					fails++;
				end
				if ($signed(m_axis_tdata[31:0]) !== want.nax) begin
					$error("new_a_x: expected %0d, got %0d", want.nax,
						$signed(m_axis_tdata[31:0]));
					fails++;
				end
				if ($signed(m_axis_tdata[63:32]) !== want.nay) begin
					$error("new_a_y: expected %0d, got %0d", want.nay,
						$signed(m_axis_tdata[63:32]));
					fails++;
				end
				if ($signed(m_axis_tdata[95:64]) !== want.nbx) begin
					$error("new_b_x: expected %0d, got %0d", want.nbx,
						$signed(m_axis_tdata[95:64]));
					fails++;
				end
				if ($signed(m_axis_tdata[127:96]) !== want.nby) begin
					$error("new_b_y: expected %0d, got %0d", want.nby,
						$signed(m_axis_tdata[127:96]));
					fails++;
				end
			end
		end
	end

endmodule

// File: files.f
+incdir+rtl
rtl/cor_pkg.sv
rtl/cor_sqrt.sv
rtl/cor_div.sv
rtl/circle_overlap_resolve_top.sv
tb/sv/testbench.sv
